// ===== hw/rtl/bmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bus master command sequencer package
// Shared widths, codes, payload layouts and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmcs_pkg;

   // Default sizes.
   localparam int BMCS_QUEUE_DEPTH  = 16;
   localparam int BMCS_LOG_DEPTH    = 16;
   localparam int BMCS_PAYLOAD_BITS = 64;

   // Field widths.
   localparam int KIND_W   = 2;
   localparam int FUNC_W   = 5;
   localparam int PAY_W    = 64;
   localparam int STATUS_W = 2;
   localparam int CODE_W   = 8;
   localparam int IDX_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int TIMER_W  = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POLL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

   // Transaction status codes.
   localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SUCCESS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAIL    = 2'd2;

   // Sequencer steps.
   localparam logic [2:0] STEP_POP     = 3'd0;
   localparam logic [2:0] STEP_EXEC    = 3'd1;
   localparam logic [2:0] STEP_TIMEOUT = 3'd2;
   localparam logic [2:0] STEP_SAVE    = 3'd3;
   localparam logic [2:0] STEP_DONE    = 3'd4;
   localparam logic [2:0] STEP_CLEAR   = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_CODE  = 8'd1;

   localparam logic [TIMER_W-1:0] TIMEOUT_LIMIT_RESET = 16'd500;
   localparam logic [CODE_W-1:0]  TIMEOUT_CODE_RESET  = 8'd255;
   localparam logic [TIMER_W-1:0] TIMER_MAX           = 16'hFFFF;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [FUNC_W-1:0]   cmd_function;
      logic [PAY_W-1:0]    cmd_payload;
      logic [STATUS_W-1:0] txn_status;
      logic [CODE_W-1:0]   slave_error_code;
      logic [IDX_W-1:0]    log_index;
   } item_type;

   typedef struct packed {
      logic [TIMER_W-1:0] timeout_limit_ms;
      logic [CODE_W-1:0]  timeout_error_code;
   } cfg_type;

   typedef struct packed {
      logic               issue_valid;
      logic [FUNC_W-1:0]  issue_function;
      logic [PAY_W-1:0]   issue_payload;
      logic               done_res;
      logic               failed;
      logic               timed_out;
      logic [COUNT_W-1:0] error_count;
      logic [CODE_W-1:0]  log_code;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bmcs_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue memory
// Ring storage for function numbers and payloads, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmcs_cmd_queue
   import bmcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = BMCS_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = BMCS_PAYLOAD_BITS,
   localparam int QA = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [QA-1:0]           wr_addr,
   input  wire logic [FUNC_W-1:0]       wr_function,
   input  wire logic [PAYLOAD_BITS-1:0] wr_payload,
   input  wire logic                    rd_en,
   input  wire logic [QA-1:0]           rd_addr,
   output logic      [FUNC_W-1:0]       rd_function,
   output logic      [PAYLOAD_BITS-1:0] rd_payload
);

   logic [FUNC_W+PAYLOAD_BITS-1:0] mem [QUEUE_DEPTH];
   logic [FUNC_W+PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_function, wr_payload};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_function = rd_data_ff[FUNC_W+PAYLOAD_BITS-1:PAYLOAD_BITS];
   assign rd_payload  = rd_data_ff[PAYLOAD_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/bmcs_err_log.sv =====
// ----------------------------------------------------------------------------
// Error log memory
// Holds logged error codes, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmcs_err_log
   import bmcs_pkg::*;
#(
   parameter int LOG_DEPTH = BMCS_LOG_DEPTH,
   localparam int LA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [LA-1:0]     wr_addr,
   input  wire logic [CODE_W-1:0] wr_code,
   input  wire logic              rd_en,
   input  wire logic [LA-1:0]     rd_addr,
   output logic      [CODE_W-1:0] rd_code
);

   logic [CODE_W-1:0] mem [LOG_DEPTH];
   logic [CODE_W-1:0] rd_code_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_code;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_code_ff <= mem[rd_addr];
      end
   end

   assign rd_code = rd_code_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bmcs_seq.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Queue pointers, sequencer step, millisecond timer and log fill count.
// Works out one result and the memory writes for the item in hand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmcs_seq
   import bmcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = BMCS_QUEUE_DEPTH,
   parameter int LOG_DEPTH    = BMCS_LOG_DEPTH,
   parameter int PAYLOAD_BITS = BMCS_PAYLOAD_BITS,
   localparam int QA = $clog2(QUEUE_DEPTH),
   localparam int LA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
   localparam int CW = $clog2(LOG_DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    exec,
   input  wire item_type                item,
   input  wire cfg_type                 cfg,
   input  wire logic [FUNC_W-1:0]       q_rd_function,
   input  wire logic [PAYLOAD_BITS-1:0] q_rd_payload,
   input  wire logic [CODE_W-1:0]       log_rd_code,
   output logic      [QA-1:0]           q_rd_addr,
   output logic                         q_wr_en,
   output logic      [QA-1:0]           q_wr_addr,
   output logic                         log_wr_en,
   output logic      [LA-1:0]           log_wr_addr,
   output logic      [CODE_W-1:0]       log_wr_code,
   output rsp_type                      rsp
);

   logic [QA-1:0]      wptr_ff, wptr_in;
   logic [QA-1:0]      rptr_ff, rptr_in;
   logic [2:0]         step_ff, step_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               do_pop;
   logic               log_add;
   logic [CODE_W-1:0]  log_add_code;

   function automatic logic [QA-1:0] ptr_inc(input logic [QA-1:0] p);
      ptr_inc = (p == QA'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_rd_addr = rptr_ff;
   assign q_wr_addr = wptr_ff;

   always_comb begin
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      step_in      = step_ff;
      timer_in     = timer_ff;
      count_in     = count_ff;
      do_pop       = 1'b0;
      log_add      = 1'b0;
      log_add_code = '0;
      q_wr_en      = 1'b0;
      log_wr_en    = 1'b0;
      log_wr_addr  = LA'(count_ff);
      log_wr_code  = '0;
      rsp          = '0;

      case (item.kind)
         KIND_PUSH: begin
            q_wr_en = exec;
            wptr_in = ptr_inc(wptr_ff);
         end
         KIND_TICK: begin
            if (timer_ff != TIMER_MAX) begin
               timer_in = timer_ff + 1'b1;
            end
         end
         KIND_POLL: begin
            case (step_ff)
               STEP_CLEAR: begin
                  // Entries at or above the fill count read as zero, so
                  // resetting the count empties the log.
                  wptr_in  = '0;
                  rptr_in  = '0;
                  count_in = '0;
                  step_in  = STEP_POP;
                  timer_in = '0;
               end
               STEP_POP: begin
                  do_pop = 1'b1;
               end
               STEP_EXEC: begin
                  if (item.txn_status == STATUS_SUCCESS) begin
                     step_in = STEP_DONE;
                  end
                  if (item.txn_status == STATUS_FAIL) begin
                     step_in = STEP_SAVE;
                  end
                  if (timer_ff > cfg.timeout_limit_ms) begin
                     step_in = STEP_TIMEOUT;
                  end
               end
               STEP_TIMEOUT: begin
                  log_add       = 1'b1;
                  log_add_code  = cfg.timeout_error_code;
                  rsp.failed    = 1'b1;
                  rsp.timed_out = 1'b1;
                  step_in       = STEP_CLEAR;
               end
               STEP_SAVE: begin
                  log_add      = 1'b1;
                  log_add_code = item.slave_error_code;
                  rsp.done_res = 1'b1;
                  rsp.failed   = 1'b1;
                  step_in      = STEP_POP;
               end
               STEP_DONE: begin
                  rsp.done_res = 1'b1;
                  step_in      = STEP_POP;
               end
               default: begin
               end
            endcase
         end
         KIND_READ: begin
            if (9'(item.log_index) < 9'(count_ff)) begin
               rsp.log_code = log_rd_code;
            end
         end
         default: begin
         end
      endcase

      if (do_pop) begin
         timer_in = '0;
         if (wptr_ff != rptr_ff) begin
            rsp.issue_valid    = 1'b1;
            rsp.issue_function = q_rd_function;
            rsp.issue_payload  = PAY_W'(q_rd_payload);
            rptr_in            = ptr_inc(rptr_ff);
            step_in            = STEP_EXEC;
         end
      end

      if (log_add && (count_ff < CW'(LOG_DEPTH))) begin
         log_wr_en   = exec;
         log_wr_code = log_add_code;
         count_in    = count_ff + 1'b1;
      end

      rsp.error_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         step_ff  <= STEP_POP;
         timer_ff <= '0;
         count_ff <= '0;
      end else if (exec) begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         step_ff  <= step_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bus_master_command_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Bus master command sequencer
// Queues bus commands, issues them on poll items, tracks their outcome
// against a millisecond timer and keeps an error log.
//
//   Channel | Direction | Handshake               | Payload
//   req     | in        | req_tvalid / req_tready | req_tdata, req_tuser (kind)
//   rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// Each item is handled in a transfer cycle, which issues the registered reads
// of the command queue and the error log, and an execute step, which updates
// state and loads the result register. The registered memory reads set this.
// A result waiting in the output register does not block the next transfer;
// the execute step holds while the register is still full.
// Reset is synchronous; the log needs no clearing pass, as its fill count
// masks entries not yet written. The csr port is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bus_master_command_sequencer_top
   import bmcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = BMCS_QUEUE_DEPTH,
   parameter int LOG_DEPTH    = BMCS_LOG_DEPTH,
   parameter int PAYLOAD_BITS = BMCS_PAYLOAD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cmd_function[4:0], cmd_payload[68:5], txn_status[70:69],
   // slave_error_code[78:71], log_index[82:79], zero pad[87:83]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // issue_valid[0], issue_function[5:1], issue_payload[69:6], done_res[70],
   // failed[71], timed_out[72], error_count[77:73], log_code[85:78],
   // zero pad[87:86]
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam int LA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_EXEC = 1'b1;

   logic     phase_ff;
   item_type item_ff;
   item_type item_in;
   cfg_type  cfg_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_calc;
   logic     rsp_valid_ff;
   logic     req_accept;
   logic     exec;

   logic [QA-1:0]           q_rd_addr;
   logic                    q_wr_en;
   logic [QA-1:0]           q_wr_addr;
   logic [FUNC_W-1:0]       q_rd_function;
   logic [PAYLOAD_BITS-1:0] q_rd_payload;
   logic                    log_wr_en;
   logic [LA-1:0]           log_wr_addr;
   logic [CODE_W-1:0]       log_wr_code;
   logic [CODE_W-1:0]       log_rd_code;

   assign req_tready = (phase_ff == PH_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exec       = (phase_ff == PH_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   always_comb begin
      item_in.kind             = req_tuser;
      item_in.cmd_function     = req_tdata[4:0];
      item_in.cmd_payload      = req_tdata[68:5];
      item_in.txn_status       = req_tdata[70:69];
      item_in.slave_error_code = req_tdata[78:71];
      item_in.log_index        = req_tdata[82:79];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (req_accept) begin
         phase_ff <= PH_EXEC;
      end else if (exec) begin
         phase_ff <= PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit_ms   <= TIMEOUT_LIMIT_RESET;
         cfg_ff.timeout_error_code <= TIMEOUT_CODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT: cfg_ff.timeout_limit_ms   <= csr_data;
            CSR_TIMEOUT_CODE:  cfg_ff.timeout_error_code <= csr_data[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.log_code, rsp_ff.error_count, rsp_ff.timed_out,
                        rsp_ff.failed, rsp_ff.done_res, rsp_ff.issue_payload,
                        rsp_ff.issue_function, rsp_ff.issue_valid};

   bmcs_cmd_queue #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_cmd_queue (
      .clock       (clock),
      .wr_en       (q_wr_en),
      .wr_addr     (q_wr_addr),
      .wr_function (item_ff.cmd_function),
      .wr_payload  (item_ff.cmd_payload[PAYLOAD_BITS-1:0]),
      .rd_en       (req_accept),
      .rd_addr     (q_rd_addr),
      .rd_function (q_rd_function),
      .rd_payload  (q_rd_payload)
   );

   bmcs_err_log #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_err_log (
      .clock   (clock),
      .wr_en   (log_wr_en),
      .wr_addr (log_wr_addr),
      .wr_code (log_wr_code),
      .rd_en   (req_accept),
      .rd_addr (LA'(item_in.log_index)),
      .rd_code (log_rd_code)
   );

   bmcs_seq #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .LOG_DEPTH    (LOG_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .exec          (exec),
      .item          (item_ff),
      .cfg           (cfg_ff),
      .q_rd_function (q_rd_function),
      .q_rd_payload  (q_rd_payload),
      .log_rd_code   (log_rd_code),
      .q_rd_addr     (q_rd_addr),
      .q_wr_en       (q_wr_en),
      .q_wr_addr     (q_wr_addr),
      .log_wr_en     (log_wr_en),
      .log_wr_addr   (log_wr_addr),
      .log_wr_code   (log_wr_code),
      .rsp           (rsp_calc)
   );

endmodule

`default_nettype wire

// ===== tb/bmcs_outcome_monitor.sv =====
// ----------------------------------------------------------------------------
// Bus master command sequencer outcome monitor
// Watches the request, result and register channels of the sequencer, keeps
// its own copy of the command ring, step, millisecond timer and error log,
// predicts one result per accepted request and compares each result field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmcs_outcome_monitor
   import bmcs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         failures,
   output int                         outstanding
);

   localparam int PTR_W = $clog2(BMCS_QUEUE_DEPTH);

   logic [FUNC_W-1:0]  ring_function [BMCS_QUEUE_DEPTH];
   logic [PAY_W-1:0]   ring_payload [BMCS_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr;
   logic [PTR_W-1:0]   rd_ptr;
   logic [2:0]         seq_step;
   logic [TIMER_W-1:0] ms_timer;
   logic [CODE_W-1:0]  error_log [BMCS_LOG_DEPTH];
   logic [COUNT_W-1:0] log_fill;
   logic [TIMER_W-1:0] timeout_limit;
   logic [CODE_W-1:0]  timeout_code;

   rsp_type pending_results[$];
   int      mismatches = 0;

   function automatic void clear_history();
      for (int i = 0; i < BMCS_QUEUE_DEPTH; i++) begin
         ring_function[i] = '0;
         ring_payload[i]  = '0;
      end
      for (int i = 0; i < BMCS_LOG_DEPTH; i++) error_log[i] = '0;
      wr_ptr   = '0;
      rd_ptr   = '0;
      log_fill = '0;
   endfunction

   // Codes that arrive with the log full are dropped.
   function automatic void append_code(input logic [CODE_W-1:0] code);
      if (log_fill < BMCS_LOG_DEPTH) begin
         error_log[log_fill[PTR_W-1:0]] = code;
         log_fill = log_fill + 1'b1;
      end
   endfunction

   function automatic rsp_type advance_sequencer(input item_type it);
      rsp_type r;
      logic    pop_now;
      r       = '0;
      pop_now = 1'b0;
      case (it.kind)
         KIND_PUSH: begin
            ring_function[wr_ptr] = it.cmd_function;
            ring_payload[wr_ptr]  = it.cmd_payload;
            wr_ptr = wr_ptr + 1'b1;
         end
         KIND_TICK: begin
            if (ms_timer != TIMER_MAX) ms_timer = ms_timer + 1'b1;
         end
         KIND_POLL: begin
            case (seq_step)
               STEP_CLEAR: begin
                  clear_history();
                  seq_step = STEP_POP;
                  pop_now  = 1'b1;
               end
               STEP_POP: pop_now = 1'b1;
               STEP_EXEC: begin
                  if (it.txn_status == STATUS_SUCCESS) seq_step = STEP_DONE;
                  if (it.txn_status == STATUS_FAIL) seq_step = STEP_SAVE;
                  // An expired timer wins over any reported status.
                  if (ms_timer > timeout_limit) seq_step = STEP_TIMEOUT;
               end
               STEP_TIMEOUT: begin
                  append_code(timeout_code);
                  r.failed    = 1'b1;
                  r.timed_out = 1'b1;
                  seq_step    = STEP_CLEAR;
               end
               STEP_SAVE: begin
                  append_code(it.slave_error_code);
                  r.done_res = 1'b1;
                  r.failed   = 1'b1;
                  seq_step   = STEP_POP;
               end
               STEP_DONE: begin
                  r.done_res = 1'b1;
                  seq_step   = STEP_POP;
               end
               default: ;
            endcase
            if (pop_now) begin
               ms_timer = '0;
               // Equal pointers look empty, even after a wrap.
               if (wr_ptr != rd_ptr) begin
                  r.issue_valid    = 1'b1;
                  r.issue_function = ring_function[rd_ptr];
                  r.issue_payload  = ring_payload[rd_ptr];
                  rd_ptr   = rd_ptr + 1'b1;
                  seq_step = STEP_EXEC;
               end
            end
         end
         default: begin
            if (it.log_index < BMCS_LOG_DEPTH) r.log_code = error_log[it.log_index];
         end
      endcase
      r.error_count = log_fill;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      item_type it;
      rsp_type  want;
      rsp_type  got;
      if (reset) begin
         clear_history();
         seq_step      = STEP_POP;
         ms_timer      = '0;
         timeout_limit = TIMEOUT_LIMIT_RESET;
         timeout_code  = TIMEOUT_CODE_RESET;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TIMEOUT_LIMIT) timeout_limit = csr_data[TIMER_W-1:0];
            else if (csr_index == CSR_TIMEOUT_CODE) timeout_code = csr_data[CODE_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            it.kind             = req_tuser;
            it.cmd_function     = req_tdata[4:0];
            it.cmd_payload      = req_tdata[68:5];
            it.txn_status       = req_tdata[70:69];
            it.slave_error_code = req_tdata[78:71];
            it.log_index        = req_tdata[82:79];
            pending_results.push_back(advance_sequencer(it));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.issue_valid    = rsp_tdata[0];
            got.issue_function = rsp_tdata[5:1];
            got.issue_payload  = rsp_tdata[69:6];
            got.done_res       = rsp_tdata[70];
            got.failed         = rsp_tdata[71];
            got.timed_out      = rsp_tdata[72];
            got.error_count    = rsp_tdata[77:73];
            got.log_code       = rsp_tdata[85:78];
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with nothing expected, expected none, actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               compare_field("issue_valid", 64'(want.issue_valid), 64'(got.issue_valid));
               compare_field("issue_function", 64'(want.issue_function),
                             64'(got.issue_function));
               compare_field("issue_payload", 64'(want.issue_payload),
                             64'(got.issue_payload));
               compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
               compare_field("failed", 64'(want.failed), 64'(got.failed));
               compare_field("timed_out", 64'(want.timed_out), 64'(got.timed_out));
               compare_field("error_count", 64'(want.error_count), 64'(got.error_count));
               compare_field("log_code", 64'(want.log_code), 64'(got.log_code));
            end
         end
      end
      outstanding <= pending_results.size();
      failures    <= mismatches;
   end

endmodule

// ===== tb/bus_master_command_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Bus master command sequencer testbench
// Drives directed and random command, tick, poll and log read transfers with
// random gaps and result stalls, steps the timeout registers through several
// settings, and reports the verdict of the outcome monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_master_command_sequencer_top_tb;
   import bmcs_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PERCENT  = 26;
   localparam logic [STATUS_W-1:0]  STATUS_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE       = 8'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int   failures;
   int   outstanding;
   int   cycle_count = 0;
   int   sent_items  = 0;
   logic quiet;

   bus_master_command_sequencer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bmcs_outcome_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bus_master_command_sequencer_top_tb failed");
         $finish;
      end
   end

   function automatic item_type random_item();
      item_type it;
      it.kind             = KIND_W'($urandom_range(3));
      it.cmd_function     = FUNC_W'($urandom_range(31));
      it.cmd_payload      = {$urandom, $urandom};
      it.txn_status       = STATUS_W'($urandom_range(3));
      it.slave_error_code = CODE_W'($urandom_range(255));
      it.log_index        = IDX_W'($urandom_range(15));
      return it;
   endfunction

   task automatic send_item(input item_type it);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {{(REQ_DATA_W - 83){1'b0}}, it.log_index, it.slave_error_code,
                     it.txn_status, it.cmd_payload, it.cmd_function};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic push_cmd(input logic [FUNC_W-1:0] func, input logic [PAY_W-1:0] payload);
      item_type it;
      it              = random_item();
      it.kind         = KIND_PUSH;
      it.cmd_function = func;
      it.cmd_payload  = payload;
      send_item(it);
   endtask

   task automatic tick();
      item_type it;
      it      = random_item();
      it.kind = KIND_TICK;
      send_item(it);
   endtask

   task automatic poll(input logic [STATUS_W-1:0] status, input logic [CODE_W-1:0] code);
      item_type it;
      it                  = random_item();
      it.kind             = KIND_POLL;
      it.txn_status       = status;
      it.slave_error_code = code;
      send_item(it);
   endtask

   task automatic read_log(input logic [IDX_W-1:0] index);
      item_type it;
      it           = random_item();
      it.kind      = KIND_READ;
      it.log_index = index;
      send_item(it);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // The upper byte of the code write is junk that the block must drop.
   task automatic configure(input logic [TIMER_W-1:0] limit, input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] junk;
      junk = CODE_W'($urandom_range(255));
      write_reg(CSR_TIMEOUT_LIMIT, limit);
      write_reg(CSR_SPARE, {junk, junk ^ code});
      write_reg(CSR_TIMEOUT_CODE, {junk, code});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed transactions: pushes, a popping poll, some ticks and
   // busy polls, an outcome poll and the poll that reports it.
   task automatic run_traffic(input int count, input int limit);
      int stop_at;
      int burst;
      int outcome;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         if ($urandom_range(99) < 8) begin
            send_item(random_item());
         end else begin
            burst = ($urandom_range(99) < 4) ? $urandom_range(18, 14) : $urandom_range(2);
            repeat (burst) push_cmd(FUNC_W'($urandom_range(31)), {$urandom, $urandom});
            poll(STATUS_W'($urandom_range(3)), CODE_W'($urandom_range(255)));
            repeat ($urandom_range(3)) begin
               if ($urandom_range(1)) tick();
               else poll($urandom_range(1) ? STATUS_BUSY : STATUS_RESERVED,
                         CODE_W'($urandom_range(255)));
            end
            outcome = $urandom_range(99);
            if (outcome < 10 && limit < 1000) repeat (limit + 1) tick();
            poll((outcome < 55) ? STATUS_SUCCESS : STATUS_FAIL,
                 CODE_W'($urandom_range(255)));
            poll(STATUS_W'($urandom_range(3)), CODE_W'($urandom_range(255)));
            if ($urandom_range(3) == 0) read_log(IDX_W'($urandom_range(15)));
         end
      end
   endtask

   initial begin
      int                mixed_limit;
      logic [CODE_W-1:0] mixed_code;
      reset      <= 1'b1;
      quiet      <= 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_PUSH;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TIMEOUT_LIMIT;
      csr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every step with a short timeout.
      configure(16'd3, 8'h5A);
      read_log(4'd0);
      read_log(4'd15);
      poll(STATUS_SUCCESS, 8'h00);
      push_cmd(5'd0, '0);
      push_cmd(5'd31, '1);
      push_cmd(5'd24, 64'hA5A5_5A5A_0F0F_F0F0);
      poll(STATUS_BUSY, 8'h00);
      poll(STATUS_BUSY, 8'h11);
      poll(STATUS_RESERVED, 8'h22);
      poll(STATUS_SUCCESS, 8'h33);
      poll(STATUS_FAIL, 8'h44);
      poll(STATUS_FAIL, 8'h55);
      poll(STATUS_FAIL, 8'h00);
      poll(STATUS_SUCCESS, 8'hFF);
      poll(STATUS_BUSY, 8'h00);
      repeat (4) tick();
      // The expired timer overrides the reported success.
      poll(STATUS_SUCCESS, 8'h00);
      poll(STATUS_FAIL, 8'h77);
      read_log(4'd1);
      poll(STATUS_BUSY, 8'h00);
      read_log(4'd0);
      wait_idle();

      configure(16'd0, 8'd1);
      run_traffic(300, 0);
      wait_idle();

      // With no timeouts possible the log fills up and saturates.
      configure(16'hFFFF, 8'hFF);
      quiet <= 1'b1;
      run_traffic(150, 65535);
      quiet <= 1'b0;
      run_traffic(250, 65535);
      wait_idle();

      mixed_limit = $urandom_range(40, 1);
      mixed_code  = CODE_W'($urandom_range(255, 1));
      configure(TIMER_W'(mixed_limit), mixed_code);
      run_traffic(500, mixed_limit);
      wait_idle();

      if (failures == 0) begin
         $display("bus_master_command_sequencer_top_tb passed");
      end else begin
         $display("bus_master_command_sequencer_top_tb failed");
      end
      $finish;
   end

endmodule
